FILE: rtl/fcbr_pkg.sv
// Shared constants for the fenced code block recognizer: result kinds,
// line phase codes, character codes and default sizes.
// No dependencies.
package fcbr_pkg;

   // default sizes
   localparam int CHAR_WIDTH_DEFAULT      = 16;
   localparam int RUN_COUNT_WIDTH_DEFAULT = 8;
   localparam int QUEUE_DEPTH_DEFAULT     = 2;

   // min_fence register
   localparam int              MIN_FENCE_WIDTH = 8;
   localparam logic [MIN_FENCE_WIDTH-1:0] MIN_FENCE_RESET = 8'd3;

   // results per request
   localparam int MAX_RESULTS        = 3;
   localparam int RESULT_COUNT_WIDTH = $clog2(MAX_RESULTS + 1);
   localparam int SLOT_INDEX_WIDTH   = $clog2(MAX_RESULTS);
   localparam int KIND_WIDTH         = 3;

   // result kinds
   localparam logic [KIND_WIDTH-1:0] KIND_CONTENT  = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_LANG     = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_OPEN     = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_CLOSE    = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_NOTFENCE = 3'd4;
   localparam logic [KIND_WIDTH-1:0] KIND_PREFIX   = 3'd5;

   // line phases
   localparam int PHASE_WIDTH = 3;
   localparam logic [PHASE_WIDTH-1:0] PH_START = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_TICKS = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_PRE   = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_WORD  = 3'd3;
   localparam logic [PHASE_WIDTH-1:0] PH_POST  = 3'd4;
   localparam logic [PHASE_WIDTH-1:0] PH_SKIP  = 3'd5;
   localparam logic [PHASE_WIDTH-1:0] PH_BODY  = 3'd6;

   // character codes
   localparam logic [7:0] CHAR_NEWLINE  = 8'd10;
   localparam logic [7:0] CHAR_SPACE    = 8'd32;
   localparam logic [7:0] CHAR_BACKTICK = 8'd96;

endpackage

FILE: rtl/fcbr_if.sv
// Channel interfaces of the fenced code block recognizer: request,
// response and configuration write. Depends on fcbr_pkg.
interface fcbr_req_if
   import fcbr_pkg::*;
#(
   parameter int CHAR_WIDTH = CHAR_WIDTH_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] in_char;
   logic                  end_of_text;

   modport source (output valid, in_char, end_of_text, input ready);
   modport sink   (input valid, in_char, end_of_text, output ready);
endinterface

interface fcbr_rsp_if
   import fcbr_pkg::*;
#(
   parameter int CHAR_WIDTH      = CHAR_WIDTH_DEFAULT,
   parameter int RUN_COUNT_WIDTH = RUN_COUNT_WIDTH_DEFAULT
);
   logic                       valid;
   logic                       ready;
   logic [KIND_WIDTH-1:0]      kind;
   logic [CHAR_WIDTH-1:0]      out_char;
   logic [RUN_COUNT_WIDTH-1:0] space_run;
   logic [RUN_COUNT_WIDTH-1:0] tick_run;
   logic                       unterminated;
   logic                       last;

   modport source (output valid, kind, out_char, space_run, tick_run, unterminated, last,
                   input ready);
   modport sink   (input valid, kind, out_char, space_run, tick_run, unterminated, last,
                   output ready);
endinterface

interface fcbr_csr_if
   import fcbr_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic [MIN_FENCE_WIDTH-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/fenced_code_block_recognizer_unit.sv
// Backtick fenced code block recognizer, one text character per request.
// A request is taken whenever the result queue (QUEUE_DEPTH entries, two by
// default) has room, so while rsp is ready a stream of characters that each
// give at most one result runs at one request per clock; results are written
// into the queue and reach rsp once their group is at its head. A request
// gives zero to three results and, while rsp is ready, the response side hands
// out one result per clock, so the queue depth sets how far requests run ahead.
// min_fence is written through csr, which is always ready; write it only
// while no results are outstanding. Depends on fcbr_pkg and fcbr_if.
module fenced_code_block_recognizer_unit
   import fcbr_pkg::*;
#(
   parameter int CHAR_WIDTH      = CHAR_WIDTH_DEFAULT,
   parameter int RUN_COUNT_WIDTH = RUN_COUNT_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   fcbr_req_if.sink   req,
   fcbr_rsp_if.source rsp,
   fcbr_csr_if.sink   csr
);

   localparam int REC_WIDTH    = KIND_WIDTH + CHAR_WIDTH + 2 * RUN_COUNT_WIDTH + 1;
   localparam int BUNDLE_WIDTH = RESULT_COUNT_WIDTH + MAX_RESULTS * REC_WIDTH;

   logic                    push_valid, push_ready;
   logic [BUNDLE_WIDTH-1:0] push_data;
   logic                    pop_valid, pop_ready;
   logic [BUNDLE_WIDTH-1:0] pop_data;

   fcbr_front #(
      .CHAR_WIDTH      (CHAR_WIDTH),
      .RUN_COUNT_WIDTH (RUN_COUNT_WIDTH),
      .REC_WIDTH       (REC_WIDTH),
      .BUNDLE_WIDTH    (BUNDLE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr        (csr),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   fcbr_queue #(
      .DATA_WIDTH (BUNDLE_WIDTH),
      .DEPTH      (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   fcbr_back #(
      .CHAR_WIDTH      (CHAR_WIDTH),
      .RUN_COUNT_WIDTH (RUN_COUNT_WIDTH),
      .REC_WIDTH       (REC_WIDTH),
      .BUNDLE_WIDTH    (BUNDLE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp)
   );

endmodule

FILE: rtl/fcbr_front.sv
// Front end: accepts requests, tracks line phase and run counts, and packs
// the one to three results of each request that gives any into one queue entry.
// Depends on fcbr_pkg and fcbr_if.
module fcbr_front
   import fcbr_pkg::*;
#(
   parameter int CHAR_WIDTH      = CHAR_WIDTH_DEFAULT,
   parameter int RUN_COUNT_WIDTH = RUN_COUNT_WIDTH_DEFAULT,
   parameter int REC_WIDTH       = KIND_WIDTH + CHAR_WIDTH + 2 * RUN_COUNT_WIDTH + 1,
   parameter int BUNDLE_WIDTH    = RESULT_COUNT_WIDTH + MAX_RESULTS * REC_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   fcbr_req_if.sink                req,
   fcbr_csr_if.sink                csr,
   output logic                    push_valid,
   input  logic                    push_ready,
   output logic [BUNDLE_WIDTH-1:0] push_data
);

   localparam int CMP_WIDTH = (RUN_COUNT_WIDTH > MIN_FENCE_WIDTH) ?
                              RUN_COUNT_WIDTH : MIN_FENCE_WIDTH;
   localparam logic [RUN_COUNT_WIDTH-1:0] RUN_MAX = {RUN_COUNT_WIDTH{1'b1}};

   logic                       in_block_ff, in_block_in;
   logic [PHASE_WIDTH-1:0]     phase_ff, phase_in;
   logic [RUN_COUNT_WIDTH-1:0] open_ff, open_in;
   logic [RUN_COUNT_WIDTH-1:0] space_ff, space_in;
   logic [RUN_COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic                       pend_ff, pend_in;
   logic [MIN_FENCE_WIDTH-1:0] min_fence_ff, min_fence_in;

   logic                          req_fire;
   logic                          is_nl, is_sp, is_tick;
   logic [RUN_COUNT_WIDTH-1:0]    space_sat, tick_sat;
   logic [CMP_WIDTH-1:0]          need_s;
   logic                          ge_open, ge_need, has_runs;
   logic [REC_WIDTH-1:0]          slot_s [MAX_RESULTS];
   logic [RESULT_COUNT_WIDTH-1:0] n_s;

   function automatic logic [REC_WIDTH-1:0] pack_rec(
      input logic [KIND_WIDTH-1:0]      kind,
      input logic [CHAR_WIDTH-1:0]      ch,
      input logic [RUN_COUNT_WIDTH-1:0] sp,
      input logic [RUN_COUNT_WIDTH-1:0] tk,
      input logic                       unt
   );
      return {kind, ch, sp, tk, unt};
   endfunction

   assign req_fire  = req.valid && req.ready;
   assign req.ready = push_ready;
   assign csr.ready = 1'b1;

   assign is_nl   = (req.in_char == CHAR_WIDTH'(CHAR_NEWLINE));
   assign is_sp   = (req.in_char == CHAR_WIDTH'(CHAR_SPACE));
   assign is_tick = (req.in_char == CHAR_WIDTH'(CHAR_BACKTICK));

   assign space_sat = (space_ff == RUN_MAX) ? space_ff : space_ff + 1'b1;
   assign tick_sat  = (tick_ff == RUN_MAX) ? tick_ff : tick_ff + 1'b1;
   // zero min_fence acts as one
   assign need_s    = (min_fence_ff == '0) ? CMP_WIDTH'(1) : CMP_WIDTH'(min_fence_ff);
   assign ge_open   = (tick_ff >= open_ff);
   assign ge_need   = (CMP_WIDTH'(tick_ff) >= need_s);
   assign has_runs  = (space_ff != '0) || (tick_ff != '0);

   assign min_fence_in = (csr.valid && csr.ready) ? csr.data : min_fence_ff;

   always_comb begin
      in_block_in = in_block_ff;
      phase_in    = phase_ff;
      open_in     = open_ff;
      space_in    = space_ff;
      tick_in     = tick_ff;
      pend_in     = pend_ff;
      n_s         = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         slot_s[i] = '0;
      end

      if (req_fire) begin
         if (req.end_of_text) begin
            if (in_block_ff) begin
               if (phase_ff == PH_TICKS && ge_open) begin
                  slot_s[n_s] = pack_rec(KIND_CLOSE, '0, '0, '0, 1'b0);
                  n_s = n_s + 1'b1;
               end else begin
                  // replay an unfinished candidate before closing
                  if (phase_ff != PH_BODY && has_runs) begin
                     if (pend_ff) begin
                        slot_s[n_s] = pack_rec(KIND_CONTENT, CHAR_WIDTH'(CHAR_NEWLINE),
                                               '0, '0, 1'b0);
                        n_s = n_s + 1'b1;
                     end
                     slot_s[n_s] = pack_rec(KIND_PREFIX, '0, space_ff, tick_ff, 1'b0);
                     n_s = n_s + 1'b1;
                  end
                  slot_s[n_s] = pack_rec(KIND_CLOSE, '0, '0, '0, 1'b1);
                  n_s = n_s + 1'b1;
               end
            end else begin
               if ((phase_ff == PH_TICKS && ge_need) || phase_ff == PH_PRE ||
                   phase_ff == PH_WORD || phase_ff == PH_POST) begin
                  slot_s[n_s] = pack_rec(KIND_OPEN, '0, '0, '0, 1'b0);
                  n_s = n_s + 1'b1;
                  slot_s[n_s] = pack_rec(KIND_CLOSE, '0, '0, '0, 1'b1);
                  n_s = n_s + 1'b1;
               end else if ((phase_ff == PH_START && space_ff != '0) ||
                            phase_ff == PH_TICKS) begin
                  slot_s[n_s] = pack_rec(KIND_NOTFENCE, '0, '0, '0, 1'b0);
                  n_s = n_s + 1'b1;
               end
            end
            in_block_in = 1'b0;
            pend_in     = 1'b0;
            open_in     = in_block_ff ? '0 : open_ff;
            phase_in    = PH_START;
            space_in    = '0;
            tick_in     = '0;
         end else if (in_block_ff) begin
            if (phase_ff == PH_BODY) begin
               if (is_nl) begin
                  // hold the break until more content follows
                  pend_in  = 1'b1;
                  phase_in = PH_START;
                  space_in = '0;
                  tick_in  = '0;
               end else begin
                  slot_s[n_s] = pack_rec(KIND_CONTENT, req.in_char, '0, '0, 1'b0);
                  n_s = n_s + 1'b1;
               end
            end else if (phase_ff == PH_START && is_sp) begin
               space_in = space_sat;
            end else if (is_tick) begin
               tick_in  = tick_sat;
               phase_in = PH_TICKS;
            end else if (is_nl && phase_ff == PH_TICKS && ge_open) begin
               slot_s[n_s] = pack_rec(KIND_CLOSE, '0, '0, '0, 1'b0);
               n_s = n_s + 1'b1;
               in_block_in = 1'b0;
               pend_in     = 1'b0;
               open_in     = '0;
               phase_in    = PH_START;
               space_in    = '0;
               tick_in     = '0;
            end else begin
               // failed candidate: held break, then replayed runs
               if (pend_ff) begin
                  slot_s[n_s] = pack_rec(KIND_CONTENT, CHAR_WIDTH'(CHAR_NEWLINE),
                                         '0, '0, 1'b0);
                  n_s = n_s + 1'b1;
               end
               if (has_runs) begin
                  slot_s[n_s] = pack_rec(KIND_PREFIX, '0, space_ff, tick_ff, 1'b0);
                  n_s = n_s + 1'b1;
               end
               space_in = '0;
               tick_in  = '0;
               if (is_nl) begin
                  pend_in  = 1'b1;
                  phase_in = PH_START;
               end else begin
                  slot_s[n_s] = pack_rec(KIND_CONTENT, req.in_char, '0, '0, 1'b0);
                  n_s = n_s + 1'b1;
                  pend_in  = 1'b0;
                  phase_in = PH_BODY;
               end
            end
         end else begin
            case (phase_ff)
               PH_START: begin
                  if (is_sp) begin
                     space_in = space_sat;
                  end else if (is_tick) begin
                     tick_in  = RUN_COUNT_WIDTH'(1);
                     phase_in = PH_TICKS;
                  end else begin
                     slot_s[n_s] = pack_rec(KIND_NOTFENCE, '0, '0, '0, 1'b0);
                     n_s = n_s + 1'b1;
                     if (is_nl) begin
                        phase_in = PH_START;
                        space_in = '0;
                        tick_in  = '0;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
               end
               PH_TICKS: begin
                  if (is_tick) begin
                     tick_in = tick_sat;
                  end else if (!ge_need) begin
                     slot_s[n_s] = pack_rec(KIND_NOTFENCE, '0, '0, '0, 1'b0);
                     n_s = n_s + 1'b1;
                     if (is_nl) begin
                        phase_in = PH_START;
                        space_in = '0;
                        tick_in  = '0;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end else if (is_nl) begin
                     slot_s[n_s] = pack_rec(KIND_OPEN, '0, '0, '0, 1'b0);
                     n_s = n_s + 1'b1;
                     in_block_in = 1'b1;
                     open_in     = tick_ff;
                     pend_in     = 1'b0;
                     phase_in    = PH_START;
                     space_in    = '0;
                     tick_in     = '0;
                  end else if (is_sp) begin
                     phase_in = PH_PRE;
                  end else begin
                     slot_s[n_s] = pack_rec(KIND_LANG, req.in_char, '0, '0, 1'b0);
                     n_s = n_s + 1'b1;
                     phase_in = PH_WORD;
                  end
               end
               PH_PRE, PH_WORD, PH_POST: begin
                  if (is_tick) begin
                     slot_s[n_s] = pack_rec(KIND_NOTFENCE, '0, '0, '0, 1'b0);
                     n_s = n_s + 1'b1;
                     phase_in = PH_SKIP;
                  end else if (is_nl) begin
                     slot_s[n_s] = pack_rec(KIND_OPEN, '0, '0, '0, 1'b0);
                     n_s = n_s + 1'b1;
                     in_block_in = 1'b1;
                     open_in     = tick_ff;
                     pend_in     = 1'b0;
                     phase_in    = PH_START;
                     space_in    = '0;
                     tick_in     = '0;
                  end else if (is_sp) begin
                     if (phase_ff == PH_WORD) begin
                        phase_in = PH_POST;
                     end
                  end else if (phase_ff != PH_POST) begin
                     slot_s[n_s] = pack_rec(KIND_LANG, req.in_char, '0, '0, 1'b0);
                     n_s = n_s + 1'b1;
                     phase_in = PH_WORD;
                  end
               end
               default: begin
                  if (is_nl) begin
                     phase_in = PH_START;
                     space_in = '0;
                     tick_in  = '0;
                  end
               end
            endcase
         end
      end
   end

   assign push_valid = req_fire && (n_s != '0);
   assign push_data  = {n_s, slot_s[2], slot_s[1], slot_s[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_block_ff  <= 1'b0;
         phase_ff     <= PH_START;
         open_ff      <= '0;
         space_ff     <= '0;
         tick_ff      <= '0;
         pend_ff      <= 1'b0;
         min_fence_ff <= MIN_FENCE_RESET;
      end else begin
         in_block_ff  <= in_block_in;
         phase_ff     <= phase_in;
         open_ff      <= open_in;
         space_ff     <= space_in;
         tick_ff      <= tick_in;
         pend_ff      <= pend_in;
         min_fence_ff <= min_fence_in;
      end
   end

endmodule

FILE: rtl/fcbr_queue.sv
// Short FIFO of packed result groups between the front and back ends.
// Depends on fcbr_pkg for its default depth.
module fcbr_queue
   import fcbr_pkg::*;
#(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output logic [DATA_WIDTH-1:0] pop_data
);

   localparam int PTR_WIDTH   = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]   PTR_LAST = PTR_WIDTH'(DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = COUNT_WIDTH'(DEPTH);

   logic [DATA_WIDTH-1:0]  entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   push_fire, pop_fire;

   assign push_ready = (count_ff != COUNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/fcbr_back.sv
// Back end: walks the queue head's results onto rsp one per cycle while
// rsp is ready and marks the last one. Depends on fcbr_pkg and fcbr_if.
module fcbr_back
   import fcbr_pkg::*;
#(
   parameter int CHAR_WIDTH      = CHAR_WIDTH_DEFAULT,
   parameter int RUN_COUNT_WIDTH = RUN_COUNT_WIDTH_DEFAULT,
   parameter int REC_WIDTH       = KIND_WIDTH + CHAR_WIDTH + 2 * RUN_COUNT_WIDTH + 1,
   parameter int BUNDLE_WIDTH    = RESULT_COUNT_WIDTH + MAX_RESULTS * REC_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  logic [BUNDLE_WIDTH-1:0] pop_data,
   fcbr_rsp_if.source              rsp
);

   logic [SLOT_INDEX_WIDTH-1:0]   idx_ff, idx_in;
   logic [RESULT_COUNT_WIDTH-1:0] count_s;
   logic [REC_WIDTH-1:0]          rec_s;
   logic                          last_s, rsp_fire;

   assign count_s  = pop_data[MAX_RESULTS*REC_WIDTH +: RESULT_COUNT_WIDTH];
   assign rec_s    = pop_data[idx_ff*REC_WIDTH +: REC_WIDTH];
   assign last_s   = (idx_ff == SLOT_INDEX_WIDTH'(count_s - 1'b1));
   assign rsp_fire = rsp.valid && rsp.ready;

   assign rsp.valid        = pop_valid;
   assign rsp.kind         = rec_s[REC_WIDTH-1 -: KIND_WIDTH];
   assign rsp.out_char     = rec_s[2*RUN_COUNT_WIDTH+1 +: CHAR_WIDTH];
   assign rsp.space_run    = rec_s[RUN_COUNT_WIDTH+1 +: RUN_COUNT_WIDTH];
   assign rsp.tick_run     = rec_s[1 +: RUN_COUNT_WIDTH];
   assign rsp.unterminated = rec_s[0];
   assign rsp.last         = last_s;

   // drop the group once its final result is taken
   assign pop_ready = rsp_fire && last_s;

   always_comb begin
      idx_in = idx_ff;
      if (rsp_fire) begin
         idx_in = last_s ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
